// ----- rtl/k_nearest_tracker_assert.svh -----
// ----------------------------------------------------------------------------
// k_nearest_tracker_assert.svh
// Assertion macros for the nearest-entry tracker, clocked on clk and held off
// while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef K_NEAREST_TRACKER_ASSERT_SVH
`define K_NEAREST_TRACKER_ASSERT_SVH

`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define KNT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define KNT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define KNT_ASSERT_IMP(label, ante, cons)
`define KNT_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ----- rtl/knt_pkg.sv -----
// ----------------------------------------------------------------------------
// knt_pkg
// Shared types and codes of the nearest-entry tracker.
// ----------------------------------------------------------------------------
package knt_pkg;

    localparam logic [1:0] ACT_SCAN   = 2'd0;
    localparam logic [1:0] ACT_UPDATE = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SNAP,
        ST_SCAN,
        ST_FIN,
        ST_DIFF,
        ST_UPD_FIND,
        ST_UPD_DEC,
        ST_UPD_NON,
        ST_READ,
        ST_FURTH,
        ST_FURTH_END,
        ST_RESULT
    } state_t;

    // Outcome of one distance and id comparison of a against b.
    typedef struct packed {
        logic farther;
        logic closer;
        logic same_dist;
    } cmp_t;

endpackage

// ----- rtl/k_nearest_tracker.sv -----
// ----------------------------------------------------------------------------
// k_nearest_tracker
// Keeps the k entries with the smallest squared distance, with scan, update
// and read items, using one shared comparator under a small sequencer.
// ----------------------------------------------------------------------------
// Order: a read item passes ST_READ, then ST_RESULT; an update searches the slots
// in ST_UPD_FIND, then ST_UPD_DEC or ST_UPD_NON, walks again in ST_FURTH when the
// furthest member must be found anew, then ST_RESULT; a first scan item walks
// ST_SNAP, a swap walks ST_FURTH, and a last one passes ST_FIN and, if needed, ST_DIFF.
// Throughput: one item at a time, s_tready returns in the cycle after the result
// is loaded; the result state waits while m_tready is low and a result is held.
// Reset (rst_n low, asynchronous) empties the table and clears k_closest.
module k_nearest_tracker #(
    parameter int K_MAX     = 16,
    parameter int DIST_BITS = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: k_closest.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    // mol_id [31:0], dist2 [79:32], slot [83:80], zero padding [87:84]
    input  logic [87:0] s_tdata,
    // action [1:0], first_item [2]
    input  logic [2:0]  s_tuser,
    // last_item
    input  logic        s_tlast,
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    // identity_changed [0], rescan_needed [1], entry_id [33:2],
    // entry_dist2 [81:34], entry_valid [82], selected_count [87:83]
    output logic [87:0] m_tdata
);

    localparam int IW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int CW = $clog2(K_MAX + 2);
    localparam int DW = DIST_BITS;
    localparam logic [IW-1:0] LAST_IDX = IW'(K_MAX - 1);
    localparam logic [CW-1:0] KMAX_C   = CW'(K_MAX);
    localparam logic [DW-1:0] DMASK    = '1;

    // Table storage; entries are only read after they have been written.
    logic [31:0]   ids_mem   [K_MAX];
    logic [DW-1:0] dists_mem [K_MAX];
    logic [31:0]   old_mem   [K_MAX];

    knt_pkg::state_t state_reg, state_next;

    logic [1:0]    act_reg, act_next;
    logic [31:0]   id_reg, id_next;
    logic [DW-1:0] d_reg, d_next;
    logic          first_reg, first_next;
    logic          last_reg, last_next;
    logic [3:0]    slot_reg, slot_next;
    logic [4:0]    k_reg, k_next;

    logic [K_MAX-1:0] valid_reg, valid_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] old_count_reg, old_count_next;
    logic [CW-1:0] seen_reg, seen_next;
    logic [CW-1:0] n_reg, n_next;
    logic [IW-1:0] fslot_reg, fslot_next;
    logic [31:0]   fid_reg, fid_next;
    logic [DW-1:0] cutoff_reg, cutoff_next;
    logic          all_sel_reg, all_sel_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] m_reg, m_next;

    logic          bfound_reg, bfound_next;
    logic [DW-1:0] bd_reg, bd_next;
    logic [31:0]   bid_reg, bid_next;
    logic [IW-1:0] bslot_reg, bslot_next;

    logic          chg_reg, chg_next;
    logic          resc_reg, resc_next;
    logic [31:0]   eid_reg, eid_next;
    logic [DW-1:0] ed_reg, ed_next;
    logic          ev_reg, ev_next;

    logic          m_tvalid_reg, m_tvalid_next;
    logic [87:0]   m_tdata_reg, m_tdata_next;

    // Table write port.
    logic          we_id, we_d, we_old;
    logic [IW-1:0] wa;
    logic [31:0]   wid;
    logic [DW-1:0] wd;

    logic [IW-1:0] rd_idx;
    logic [31:0]   rd_id;
    logic [DW-1:0] rd_d;
    logic [CW-1:0] keff;
    logic          has_f;
    logic [IW-1:0] free_idx;
    logic          free_any;
    logic          old_hit;
    logic          in_acc;

    logic [DW-1:0] cmp_a_d, cmp_b_d;
    logic [31:0]   cmp_a_id, cmp_b_id;
    knt_pkg::cmp_t cmp;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == knt_pkg::ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // The effective k never exceeds the table depth.
    assign keff  = (32'(k_reg) > K_MAX) ? KMAX_C : CW'(k_reg);
    // A furthest member is tracked only while the set is bounded and non-empty.
    assign has_f = !all_sel_reg && (count_reg != '0);

    // Single read port, addressed by the walk counter or by a read item's slot.
    assign rd_idx = (state_reg == knt_pkg::ST_READ) ? IW'(slot_reg) : idx_reg;
    assign rd_id  = ids_mem[rd_idx];
    assign rd_d   = dists_mem[rd_idx];

    // Lowest free slot.
    always_comb
    begin
        free_idx = '0;
        for (int i = K_MAX - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IW'(i);
            end
        end
        free_any = !(&valid_reg);
    end

    // The walked member against every id of the snapshot at once.
    always_comb
    begin
        old_hit = 1'b0;
        for (int j = 0; j < K_MAX; j++)
        begin
            if ((CW'(j) < old_count_reg) && (old_mem[j] == rd_id))
            begin
                old_hit = 1'b1;
            end
        end
    end

    // While searching for the furthest member the comparator weighs the walked
    // member against the best so far; otherwise the candidate against the cutoff.
    always_comb
    begin
        if (state_reg == knt_pkg::ST_FURTH)
        begin
            cmp_a_d  = rd_d;
            cmp_a_id = rd_id;
            cmp_b_d  = bd_reg;
            cmp_b_id = bid_reg;
        end
        else
        begin
            cmp_a_d  = d_reg;
            cmp_a_id = id_reg;
            cmp_b_d  = cutoff_reg;
            cmp_b_id = fid_reg;
        end
    end

    knt_dist_cmp #(
        .DW(DW)
    ) u_cmp (
        .a_dist(cmp_a_d),
        .a_id  (cmp_a_id),
        .b_dist(cmp_b_d),
        .b_id  (cmp_b_id),
        .result(cmp)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            knt_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (s_tuser[1:0])
                        knt_pkg::ACT_SCAN:
                            state_next = s_tuser[2] ? knt_pkg::ST_SNAP : knt_pkg::ST_SCAN;
                        knt_pkg::ACT_UPDATE: state_next = knt_pkg::ST_UPD_FIND;
                        knt_pkg::ACT_READ:   state_next = knt_pkg::ST_READ;
                        default:             state_next = knt_pkg::ST_IDLE;
                    endcase
                end
            end
            knt_pkg::ST_SNAP:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = knt_pkg::ST_SCAN;
                end
            end
            knt_pkg::ST_SCAN:
            begin
                if (keff != '0 && count_reg >= keff && has_f && cmp.closer)
                begin
                    state_next = knt_pkg::ST_FURTH;
                end
                else
                begin
                    state_next = last_reg ? knt_pkg::ST_FIN : knt_pkg::ST_IDLE;
                end
            end
            knt_pkg::ST_FIN:
            begin
                if (keff != '0 && count_reg == old_count_reg)
                begin
                    state_next = knt_pkg::ST_DIFF;
                end
                else
                begin
                    state_next = knt_pkg::ST_RESULT;
                end
            end
            knt_pkg::ST_DIFF:
            begin
                if ((valid_reg[idx_reg] && !old_hit) || idx_reg == LAST_IDX)
                begin
                    state_next = knt_pkg::ST_RESULT;
                end
            end
            knt_pkg::ST_UPD_FIND:
            begin
                if (valid_reg[idx_reg] && rd_id == id_reg)
                begin
                    state_next = knt_pkg::ST_UPD_DEC;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = knt_pkg::ST_UPD_NON;
                end
            end
            knt_pkg::ST_UPD_DEC:
            begin
                if (!all_sel_reg && !cmp.farther &&
                    (cmp.same_dist || m_reg == fslot_reg))
                begin
                    state_next = knt_pkg::ST_FURTH;
                end
                else
                begin
                    state_next = knt_pkg::ST_RESULT;
                end
            end
            knt_pkg::ST_UPD_NON:
            begin
                if (!all_sel_reg && has_f && cmp.closer)
                begin
                    state_next = knt_pkg::ST_FURTH;
                end
                else
                begin
                    state_next = knt_pkg::ST_RESULT;
                end
            end
            knt_pkg::ST_READ:
            begin
                state_next = knt_pkg::ST_RESULT;
            end
            knt_pkg::ST_FURTH:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = knt_pkg::ST_FURTH_END;
                end
            end
            knt_pkg::ST_FURTH_END:
            begin
                if (act_reg == knt_pkg::ACT_SCAN)
                begin
                    state_next = last_reg ? knt_pkg::ST_FIN : knt_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = knt_pkg::ST_RESULT;
                end
            end
            knt_pkg::ST_RESULT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = knt_pkg::ST_IDLE;
                end
            end
            default: state_next = knt_pkg::ST_IDLE;
        endcase
    end

    // Datapath and table control.
    always_comb
    begin
        act_next       = act_reg;
        id_next        = id_reg;
        d_next         = d_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        slot_next      = slot_reg;
        k_next         = k_reg;
        valid_next     = valid_reg;
        count_next     = count_reg;
        old_count_next = old_count_reg;
        seen_next      = seen_reg;
        n_next         = n_reg;
        fslot_next     = fslot_reg;
        fid_next       = fid_reg;
        cutoff_next    = cutoff_reg;
        all_sel_next   = all_sel_reg;
        idx_next       = idx_reg;
        m_next         = m_reg;
        bfound_next    = bfound_reg;
        bd_next        = bd_reg;
        bid_next       = bid_reg;
        bslot_next     = bslot_reg;
        chg_next       = chg_reg;
        resc_next      = resc_reg;
        eid_next       = eid_reg;
        ed_next        = ed_reg;
        ev_next        = ev_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        we_id          = 1'b0;
        we_d           = 1'b0;
        we_old         = 1'b0;
        wa             = free_idx;
        wid            = id_reg;
        wd             = d_reg;

        if (cfg_valid)
        begin
            k_next = cfg_data;
        end

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            knt_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    act_next    = s_tuser[1:0];
                    first_next  = s_tuser[2];
                    last_next   = s_tlast;
                    id_next     = s_tdata[31:0];
                    d_next      = DW'(s_tdata[79:32]);
                    slot_next   = s_tdata[83:80];
                    idx_next    = '0;
                    n_next      = '0;
                    bfound_next = 1'b0;
                    chg_next    = 1'b0;
                    resc_next   = 1'b0;
                    ev_next     = 1'b0;
                    eid_next    = '0;
                    ed_next     = '0;
                end
            end
            knt_pkg::ST_SNAP:
            begin
                // Valid members are packed into the snapshot in slot order.
                if (valid_reg[idx_reg])
                begin
                    we_old = 1'b1;
                    n_next = n_reg + CW'(1);
                end
                idx_next = idx_reg + IW'(1);
                if (idx_reg == LAST_IDX)
                begin
                    old_count_next = n_reg + CW'(valid_reg[idx_reg]);
                    valid_next     = '0;
                    count_next     = '0;
                    seen_next      = '0;
                    fslot_next     = '0;
                    cutoff_next    = '0;
                    all_sel_next   = 1'b0;
                end
            end
            knt_pkg::ST_SCAN:
            begin
                if (seen_reg <= KMAX_C)
                begin
                    seen_next = seen_reg + CW'(1);
                end
                if (keff != '0)
                begin
                    if (count_reg < keff)
                    begin
                        if (count_reg == '0 || cmp.farther)
                        begin
                            fslot_next  = free_idx;
                            cutoff_next = d_reg;
                            fid_next    = id_reg;
                        end
                        we_id                = 1'b1;
                        we_d                 = 1'b1;
                        valid_next[free_idx] = 1'b1;
                        count_next           = count_reg + CW'(1);
                    end
                    else if (has_f && cmp.closer)
                    begin
                        wa          = fslot_reg;
                        we_id       = 1'b1;
                        we_d        = 1'b1;
                        idx_next    = '0;
                        bfound_next = 1'b0;
                    end
                end
            end
            knt_pkg::ST_FIN:
            begin
                idx_next = '0;
                if (keff != '0)
                begin
                    // A scan no longer than k selects every item it saw.
                    if (seen_reg <= keff)
                    begin
                        all_sel_next = 1'b1;
                        cutoff_next  = DMASK;
                    end
                    if (count_reg != old_count_reg)
                    begin
                        chg_next = 1'b1;
                    end
                end
            end
            knt_pkg::ST_DIFF:
            begin
                if (valid_reg[idx_reg] && !old_hit)
                begin
                    chg_next = 1'b1;
                end
                idx_next = idx_reg + IW'(1);
            end
            knt_pkg::ST_UPD_FIND:
            begin
                m_next   = idx_reg;
                idx_next = idx_reg + IW'(1);
            end
            knt_pkg::ST_UPD_DEC:
            begin
                wa          = m_reg;
                idx_next    = '0;
                bfound_next = 1'b0;
                if (all_sel_reg || !cmp.farther)
                begin
                    we_d = 1'b1;
                end
                else
                begin
                    resc_next = 1'b1;
                end
            end
            knt_pkg::ST_UPD_NON:
            begin
                idx_next    = '0;
                bfound_next = 1'b0;
                if (all_sel_reg)
                begin
                    if (count_reg < keff && free_any)
                    begin
                        we_id                = 1'b1;
                        we_d                 = 1'b1;
                        valid_next[free_idx] = 1'b1;
                        count_next           = count_reg + CW'(1);
                        chg_next             = 1'b1;
                    end
                    else
                    begin
                        resc_next = 1'b1;
                    end
                end
                else if (has_f && cmp.closer)
                begin
                    wa       = fslot_reg;
                    we_id    = 1'b1;
                    we_d     = 1'b1;
                    chg_next = 1'b1;
                end
            end
            knt_pkg::ST_READ:
            begin
                if (({28'd0, slot_reg} < 32'(K_MAX)) && valid_reg[rd_idx])
                begin
                    ev_next  = 1'b1;
                    eid_next = rd_id;
                    ed_next  = rd_d;
                end
            end
            knt_pkg::ST_FURTH:
            begin
                if (valid_reg[idx_reg] && (!bfound_reg || cmp.farther))
                begin
                    bfound_next = 1'b1;
                    bd_next     = rd_d;
                    bid_next    = rd_id;
                    bslot_next  = idx_reg;
                end
                idx_next = idx_reg + IW'(1);
            end
            knt_pkg::ST_FURTH_END:
            begin
                fslot_next  = bfound_reg ? bslot_reg : '0;
                cutoff_next = bfound_reg ? bd_reg : '0;
                fid_next    = bid_reg;
            end
            knt_pkg::ST_RESULT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'(count_reg), ev_reg, 48'(ed_reg), eid_reg,
                                     resc_reg, chg_reg};
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    // Table arrays.
    always_ff @(posedge clk)
    begin
        if (we_id)
        begin
            ids_mem[wa] <= wid;
        end
        if (we_d)
        begin
            dists_mem[wa] <= wd;
        end
        if (we_old)
        begin
            old_mem[n_reg[IW-1:0]] <= rd_id;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        id_reg      <= id_next;
        d_reg       <= d_next;
        first_reg   <= first_next;
        last_reg    <= last_next;
        slot_reg    <= slot_next;
        idx_reg     <= idx_next;
        m_reg       <= m_next;
        n_reg       <= n_next;
        bfound_reg  <= bfound_next;
        bd_reg      <= bd_next;
        bid_reg     <= bid_next;
        bslot_reg   <= bslot_next;
        chg_reg     <= chg_next;
        resc_reg    <= resc_next;
        eid_reg     <= eid_next;
        ed_reg      <= ed_next;
        ev_reg      <= ev_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= knt_pkg::ST_IDLE;
            k_reg         <= '0;
            valid_reg     <= '0;
            count_reg     <= '0;
            old_count_reg <= '0;
            seen_reg      <= '0;
            fslot_reg     <= '0;
            fid_reg       <= '0;
            cutoff_reg    <= '0;
            all_sel_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            old_count_reg <= old_count_next;
            seen_reg      <= seen_next;
            fslot_reg     <= fslot_next;
            fid_reg       <= fid_next;
            cutoff_reg    <= cutoff_next;
            all_sel_reg   <= all_sel_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    `include "k_nearest_tracker_assert.svh"

    // The fill count always agrees with the valid bits.
    `KNT_ASSERT_IMP(a_count_matches, 1'b1, $countones(valid_reg) == 32'(count_reg))
    // Once every scanned item is selected the cutoff stays unbounded.
    `KNT_ASSERT_IMP(a_all_sel_cutoff, all_sel_reg, cutoff_reg == DMASK)
    // A result is only loaded from the result state.
    `KNT_ASSERT_NXT(a_result_from_state, !m_tvalid_reg && state_reg != knt_pkg::ST_RESULT,
                    !m_tvalid_reg)

endmodule

// ----- rtl/knt_dist_cmp.sv -----
// ----------------------------------------------------------------------------
// knt_dist_cmp
// Shared comparator: orders two entries by distance, ties by id.
// ----------------------------------------------------------------------------
module knt_dist_cmp #(
    parameter int DW = 48
) (
    input  logic [DW-1:0] a_dist,
    input  logic [31:0]   a_id,
    input  logic [DW-1:0] b_dist,
    input  logic [31:0]   b_id,
    output knt_pkg::cmp_t result
);

    always_comb
    begin
        result.same_dist = (a_dist == b_dist);
        result.farther   = (a_dist > b_dist) || (result.same_dist && (a_id > b_id));
        result.closer    = (a_dist < b_dist) || (result.same_dist && (a_id < b_id));
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking test of the nearest-entry tracker. Scan, update and read items
// go in through the input stream, mostly while both sides idle at random. A model of
// the member table inside this file works out each expected result item, and
// a monitor compares every result item with the oldest expected one.
// ----------------------------------------------------------------------------
module tb;

    localparam int KMAX = 16;
    localparam logic [47:0] DIST_ALL_ONES = 48'hFFFF_FFFF_FFFF;
    localparam int TIMEOUT_CYCLES = 3000000;
    // An action code that the block does not know.
    localparam logic [1:0] ACT_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] mol_id;
        logic [47:0] dist2;
        logic        first_item;
        logic        last_item;
        logic [3:0]  slot;
    } query_t;

    typedef struct packed {
        logic        identity_changed;
        logic        rescan_needed;
        logic [31:0] entry_id;
        logic [47:0] entry_dist2;
        logic        entry_valid;
        logic [4:0]  selected_count;
    } answer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;

    k_nearest_tracker uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Model of the member table, updated as each item is accepted.
    // ------------------------------------------------------------------
    logic [4:0]  k_setting;
    logic [31:0] tbl_id    [KMAX];
    logic [47:0] tbl_dist  [KMAX];
    logic        tbl_valid [KMAX];
    logic [31:0] prev_id   [KMAX];
    int          prev_count;
    int          seen_count;
    int          far_slot;
    logic [47:0] far_dist;
    logic        everything_kept;

    query_t  pending_items [$];
    answer_t expected_answers [$];

    function automatic int k_eff();
        return (k_setting > KMAX) ? KMAX : int'(k_setting);
    endfunction

    function automatic int members();
        int n;
        n = 0;
        for (int i = 0; i < KMAX; i++)
            if (tbl_valid[i]) n++;
        return n;
    endfunction

    function automatic int lowest_free();
        for (int i = 0; i < KMAX; i++)
            if (!tbl_valid[i]) return i;
        return -1;
    endfunction

    // Finds the furthest member; equal distances go to the larger id.
    task automatic refresh_furthest();
        logic        found;
        logic [47:0] best;
        int          bs;
        found = 1'b0;
        best = '0;
        bs = 0;
        for (int i = 0; i < KMAX; i++) begin
            if (tbl_valid[i] && (!found || tbl_dist[i] > best ||
                (tbl_dist[i] == best && tbl_id[i] > tbl_id[bs]))) begin
                found = 1'b1;
                best = tbl_dist[i];
                bs = i;
            end
        end
        far_slot = bs;
        far_dist = found ? best : '0;
    endtask

    function automatic logic beats_furthest(logic [31:0] id, logic [47:0] d);
        return d < far_dist || (d == far_dist && id < tbl_id[far_slot]);
    endfunction

    function automatic logic membership_changed();
        logic hit;
        if (members() != prev_count) return 1'b1;
        for (int i = 0; i < KMAX; i++) begin
            if (!tbl_valid[i]) continue;
            hit = 1'b0;
            for (int j = 0; j < prev_count; j++)
                if (prev_id[j] == tbl_id[i]) hit = 1'b1;
            if (!hit) return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic put_entry(int s, logic [31:0] id, logic [47:0] d);
        tbl_id[s] = id;
        tbl_dist[s] = d;
        tbl_valid[s] = 1'b1;
    endtask

    task automatic take_scan(logic [31:0] id, logic [47:0] d);
        int n;
        int s;
        n = members();
        if (seen_count <= KMAX) seen_count++;
        if (k_eff() == 0) return;
        if (n < k_eff()) begin
            s = lowest_free();
            if (n == 0 || d > far_dist || (d == far_dist && id > tbl_id[far_slot])) begin
                far_slot = s;
                far_dist = d;
            end
            put_entry(s, id, d);
        end else if (!everything_kept && n > 0 && beats_furthest(id, d)) begin
            put_entry(far_slot, id, d);
            refresh_furthest();
        end
    endtask

    // Applies one accepted item and queues the result it causes, if any.
    task automatic track_item(query_t q);
        answer_t a;
        int      m;
        int      s;
        int      n;
        logic    was_far;
        a = '0;
        if (q.action == knt_pkg::ACT_SCAN) begin
            if (q.first_item) begin
                n = 0;
                for (int i = 0; i < KMAX; i++)
                    if (tbl_valid[i]) begin
                        prev_id[n] = tbl_id[i];
                        n++;
                    end
                prev_count = n;
                for (int i = 0; i < KMAX; i++) tbl_valid[i] = 1'b0;
                seen_count = 0;
                far_slot = 0;
                far_dist = '0;
                everything_kept = 1'b0;
            end
            take_scan(q.mol_id, q.dist2);
            if (!q.last_item) return;
            if (k_eff() > 0) begin
                if (seen_count <= k_eff()) begin
                    everything_kept = 1'b1;
                    far_dist = DIST_ALL_ONES;
                end
                a.identity_changed = membership_changed();
            end
        end else if (q.action == knt_pkg::ACT_UPDATE) begin
            m = -1;
            for (int i = KMAX - 1; i >= 0; i--)
                if (tbl_valid[i] && tbl_id[i] == q.mol_id) m = i;
            if (m >= 0) begin
                if (everything_kept)
                    tbl_dist[m] = q.dist2;
                else if (q.dist2 > far_dist ||
                         (q.dist2 == far_dist && q.mol_id > tbl_id[far_slot]))
                    a.rescan_needed = 1'b1;
                else begin
                    was_far = (m == far_slot);
                    tbl_dist[m] = q.dist2;
                    if (q.dist2 == far_dist || was_far) refresh_furthest();
                end
            end else if (everything_kept) begin
                s = lowest_free();
                if (members() < k_eff() && s >= 0) begin
                    put_entry(s, q.mol_id, q.dist2);
                    a.identity_changed = 1'b1;
                end else
                    a.rescan_needed = 1'b1;
            end else if (members() > 0 && beats_furthest(q.mol_id, q.dist2)) begin
                put_entry(far_slot, q.mol_id, q.dist2);
                refresh_furthest();
                a.identity_changed = 1'b1;
            end
        end else if (q.action == knt_pkg::ACT_READ) begin
            if (tbl_valid[q.slot]) begin
                a.entry_id = tbl_id[q.slot];
                a.entry_dist2 = tbl_dist[q.slot];
                a.entry_valid = 1'b1;
            end
        end else
            return;
        a.selected_count = 5'(members());
        expected_answers.push_back(a);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued items, idling in random bursts while allowed.
    // ------------------------------------------------------------------
    logic sender_idle_on = 1'b0;
    logic receiver_idle_on = 1'b0;
    int   send_gap = 0;
    int   recv_gap = 0;
    int   hold_off = 0;
    int   mismatches = 0;
    int   items_taken = 0;
    // Set when the item on the input was taken at the last rising edge.
    logic s_tready_q = 1'b0;

    always @(negedge clk) begin
        if (rst_n) begin
            if (!s_tvalid || s_tready_q) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0 &&
                             !(sender_idle_on && $urandom_range(0, 9) == 0)) begin
                    query_t q;
                    q = pending_items.pop_front();
                    s_tdata <= {4'b0, q.slot, q.dist2, q.mol_id};
                    s_tuser <= {q.first_item, q.action};
                    s_tlast <= q.last_item;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                    if (sender_idle_on) send_gap <= $urandom_range(1, 17);
                end
            end
        end
    end

    // Input side handshake: the model takes each item as it is accepted.
    always @(posedge clk) begin
        s_tready_q <= s_tvalid && s_tready ? 1'b1 : 1'b0;
        if (rst_n && s_tvalid && s_tready) begin
            query_t q;
            q.slot = s_tdata[83:80];
            q.dist2 = s_tdata[79:32];
            q.mol_id = s_tdata[31:0];
            q.action = s_tuser[1:0];
            q.first_item = s_tuser[2];
            q.last_item = s_tlast;
            track_item(q);
            items_taken++;
        end
    end

    // Receiver side: random bursts of stall, plus one long hold-off on request.
    always @(negedge clk) begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_tready <= 1'b0;
        end else if (receiver_idle_on && $urandom_range(0, 7) == 0) begin
            recv_gap <= $urandom_range(1, 17);
            m_tready <= 1'b0;
        end else
            m_tready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Monitor: compares each result item with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            answer_t got;
            answer_t want;
            got.identity_changed = m_tdata[0];
            got.rescan_needed = m_tdata[1];
            got.entry_id = m_tdata[33:2];
            got.entry_dist2 = m_tdata[81:34];
            got.entry_valid = m_tdata[82];
            got.selected_count = m_tdata[87:83];
            if (expected_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item %h", got);
            end else begin
                want = expected_answers.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected chg=%0b rescan=%0b id=%h d=%h",
                                  " v=%0b n=%0d, got chg=%0b rescan=%0b id=%h d=%h",
                                  " v=%0b n=%0d"},
                            want.identity_changed, want.rescan_needed, want.entry_id,
                            want.entry_dist2, want.entry_valid, want.selected_count,
                            got.identity_changed, got.rescan_needed, got.entry_id,
                            got.entry_dist2, got.entry_valid, got.selected_count);
                end
            end
        end
    end

    // Overall cycle limit.
    int cycle_count = 0;
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("k_nearest_tracker regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus building.
    // ------------------------------------------------------------------
    int queued = 0;

    function automatic query_t make_item(logic [1:0] act, logic [31:0] id, logic [47:0] d,
                                         logic f, logic l, logic [3:0] s);
        query_t q;
        q.action = act;
        q.mol_id = id;
        q.dist2 = d;
        q.first_item = f;
        q.last_item = l;
        q.slot = s;
        return q;
    endfunction

    function automatic logic [47:0] rand_dist();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return DIST_ALL_ONES;
            2: return 48'($urandom_range(0, 7));
            default: return {16'($urandom), 32'($urandom)};
        endcase
    endfunction

    // Ids come from a small pool so that updates hit members and scans repeat ids.
    logic [31:0] id_pool [8];

    function automatic logic [31:0] rand_id();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return id_pool[$urandom_range(0, 7)];
    endfunction

    task automatic queue_item(query_t q);
        pending_items.push_back(q);
        queued++;
    endtask

    task automatic queue_scan(int len, logic with_first);
        for (int i = 0; i < len; i++)
            queue_item(make_item(knt_pkg::ACT_SCAN, rand_id(), rand_dist(),
                                 with_first && i == 0, i == len - 1, 4'($urandom)));
    endtask

    // Waits until everything sent has been answered, then lets the block settle.
    task automatic drain();
        while (pending_items.size() > 0 || s_tvalid || expected_answers.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_k(logic [4:0] value);
        @(negedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        k_setting = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int count);
        int target;
        int r;
        target = queued + count;
        while (queued < target) begin
            r = $urandom_range(0, 9);
            if (r < 4) queue_scan($urandom_range(1, 24), $urandom_range(0, 9) != 0);
            else if (r < 7)
                queue_item(make_item(knt_pkg::ACT_UPDATE, rand_id(), rand_dist(),
                                     1'($urandom), 1'($urandom), 4'($urandom)));
            else if (r < 9)
                queue_item(make_item(knt_pkg::ACT_READ, $urandom, rand_dist(),
                                     1'($urandom), 1'($urandom), 4'($urandom)));
            else
                queue_item(make_item(ACT_UNKNOWN, $urandom, rand_dist(),
                                     1'($urandom), 1'($urandom), 4'($urandom)));
        end
    endtask

    initial begin
        logic [4:0] k_values [8];
        k_setting = '0;
        prev_count = 0;
        seen_count = 0;
        far_slot = 0;
        far_dist = '0;
        everything_kept = 1'b0;
        for (int i = 0; i < KMAX; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_id[i] = '0;
            tbl_dist[i] = '0;
            prev_id[i] = '0;
        end
        for (int i = 0; i < 8; i++) id_pool[i] = (i == 7) ? 32'hFFFF_FFFF : 32'(i * 3);
        k_values = '{5'd4, 5'd0, 5'd16, 5'd31, 5'd1, 5'd17, 5'd8, 5'd3};

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part with k of four: reads of an empty table, a scan that
        // fills and then replaces with equal-distance ties, member and
        // non-member updates, a small scan that keeps everything, and an
        // unknown action.
        write_k(5'd4);
        queue_item(make_item(knt_pkg::ACT_READ, 32'd0, 48'd0, 1'b0, 1'b0, 4'd15));
        queue_item(make_item(knt_pkg::ACT_UPDATE, 32'd5, 48'd9, 1'b0, 1'b0, 4'd0));
        queue_item(make_item(knt_pkg::ACT_SCAN, 32'hFFFF_FFFF, DIST_ALL_ONES,
                             1'b1, 1'b0, 4'd0));
        queue_item(make_item(knt_pkg::ACT_SCAN, 32'd1, 48'd10, 1'b0, 1'b0, 4'd0));
        queue_item(make_item(knt_pkg::ACT_SCAN, 32'd2, 48'd10, 1'b0, 1'b0, 4'd0));
        queue_item(make_item(knt_pkg::ACT_SCAN, 32'd3, 48'd20, 1'b0, 1'b0, 4'd0));
        queue_item(make_item(knt_pkg::ACT_SCAN, 32'd0, 48'd0, 1'b0, 1'b0, 4'd0));
        queue_item(make_item(knt_pkg::ACT_SCAN, 32'd2, 48'd10, 1'b0, 1'b0, 4'd0));
        queue_item(make_item(knt_pkg::ACT_SCAN, 32'd4, 48'd20, 1'b0, 1'b1, 4'd0));
        queue_item(make_item(knt_pkg::ACT_UPDATE, 32'd1, 48'd5, 1'b0, 1'b0, 4'd0));
        queue_item(make_item(knt_pkg::ACT_UPDATE, 32'd2, DIST_ALL_ONES, 1'b0, 1'b0, 4'd0));
        queue_item(make_item(knt_pkg::ACT_UPDATE, 32'd9, 48'd1, 1'b0, 1'b0, 4'd0));
        queue_item(make_item(knt_pkg::ACT_READ, 32'd0, 48'd0, 1'b0, 1'b0, 4'd0));
        queue_item(make_item(knt_pkg::ACT_READ, 32'd0, 48'd0, 1'b0, 1'b0, 4'd3));
        queue_item(make_item(knt_pkg::ACT_SCAN, 32'd7, 48'd3, 1'b1, 1'b0, 4'd0));
        queue_item(make_item(knt_pkg::ACT_SCAN, 32'd8, 48'd3, 1'b0, 1'b1, 4'd0));
        queue_item(make_item(knt_pkg::ACT_UPDATE, 32'd7, DIST_ALL_ONES, 1'b0, 1'b0, 4'd0));
        queue_item(make_item(knt_pkg::ACT_UPDATE, 32'd11, 48'd2, 1'b0, 1'b0, 4'd0));
        queue_item(make_item(knt_pkg::ACT_UPDATE, 32'd12, 48'd2, 1'b0, 1'b0, 4'd0));
        queue_item(make_item(knt_pkg::ACT_UPDATE, 32'd13, 48'd2, 1'b0, 1'b0, 4'd0));
        queue_item(make_item(knt_pkg::ACT_SCAN, 32'd14, 48'd1, 1'b0, 1'b1, 4'd0));
        queue_item(make_item(ACT_UNKNOWN, 32'd1, 48'd1, 1'b1, 1'b1, 4'd0));
        queue_item(make_item(knt_pkg::ACT_READ, 32'd0, 48'd0, 1'b0, 1'b0, 4'd1));
        drain();

        // Long hold-off of the receiver so that the block backs up.
        hold_off = 400;
        sender_idle_on = 1'b1;
        receiver_idle_on = 1'b1;
        for (int p = 0; p < 8; p++) begin
            write_k(k_values[p]);
            random_phase(200);
            drain();
        end
        sender_idle_on = 1'b0;
        receiver_idle_on = 1'b0;
        random_phase(200);
        drain();

        if (mismatches == 0)
            $display("k_nearest_tracker regression: pass");
        else
            $display("k_nearest_tracker regression: fail");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/knt_pkg.sv
rtl/knt_dist_cmp.sv
rtl/k_nearest_tracker.sv
tb/tb.sv
